// File: hw/rtl/sabp_pkg.sv
// Shared types, constants and helper functions for the six-axis ball packet parser.
package sabp_pkg;

	// Receive buffer limit: a packet is dropped once its count reaches BUFFER_BYTES-1
	localparam int unsigned BUFFER_BYTES = 64;
	localparam int unsigned CNT_W        = 8;
	localparam int unsigned STORE_DEPTH  = 12;
	localparam int unsigned STORE_IDX_W  = $clog2(STORE_DEPTH);
	localparam int unsigned KEY_LEN      = 9;

	// Start and protocol bytes
	localparam logic [7:0] CH_RESET  = 8'h52; // R
	localparam logic [7:0] CH_BALL   = 8'h44; // D
	localparam logic [7:0] CH_BUTTON = 8'h4B; // K
	localparam logic [7:0] CH_ERROR  = 8'h45; // E
	localparam logic [7:0] CH_NULL   = 8'h4E; // N
	localparam logic [7:0] CH_CR     = 8'h0D;

	// Null-region requests at or above this value are dropped
	localparam logic [7:0] REGION_LIMIT = 8'd129;

	// Descramble key for ball data bytes 2..10
	localparam logic [7:0] DESC_KEY [KEY_LEN] = '{
		8'h53, 8'h70, 8'h61, 8'h63, 8'h65, 8'h57, 8'h61, 8'h72, 8'h65
	};

	typedef enum logic [2:0] {
		PKT_RESET  = 3'd0,
		PKT_BALL   = 3'd1,
		PKT_BUTTON = 3'd2,
		PKT_ERROR  = 3'd3,
		PKT_NULL   = 3'd4,
		PKT_TERM   = 3'd5,
		PKT_NONE   = 3'd7
	} pkt_t;

	// Position of a result within the group caused by one completed packet
	typedef enum logic [1:0] {
		SLOT_REPORT = 2'd0,
		SLOT_N      = 2'd1,
		SLOT_REGION = 2'd2,
		SLOT_CR     = 2'd3
	} slot_t;

	typedef logic signed [9:0] axis_t;

	typedef struct packed {
		axis_t tx;
		axis_t ty;
		axis_t tz;
		axis_t rx;
		axis_t ry;
		axis_t rz;
	} axes_t;

	// Result group handed from the parser to the output serializer
	typedef struct packed {
		pkt_t       ptype;
		logic       tx_en;
		logic [7:0] region;
	} grp_t;

	function automatic pkt_t start_code(input logic [7:0] ch);
		pkt_t code;
		case (ch)
			CH_RESET:  code = PKT_RESET;
			CH_BALL:   code = PKT_BALL;
			CH_BUTTON: code = PKT_BUTTON;
			CH_ERROR:  code = PKT_ERROR;
			CH_NULL:   code = PKT_NULL;
			CH_CR:     code = PKT_TERM;
			default:   code = PKT_NONE;
		endcase
		return code;
	endfunction

	function automatic logic [CNT_W-1:0] pkt_len(input pkt_t p);
		logic [CNT_W-1:0] len;
		case (p)
			PKT_RESET:  len = CNT_W'(51);
			PKT_BALL:   len = CNT_W'(12);
			PKT_BUTTON: len = CNT_W'(5);
			PKT_ERROR:  len = CNT_W'(4);
			PKT_NULL:   len = CNT_W'(3);
			PKT_TERM:   len = CNT_W'(1);
			default:    len = '0;
		endcase
		return len;
	endfunction

endpackage

// File: hw/rtl/six_axis_ball_packet_parser_unit.sv
// An item is parsed in the input register; its report is offered once the item commits.
// Throughput: one item per cycle unless stalled; a completed packet with a null-region request
// below REGION_LIMIT gives four results; input stalls only on completion while a group is busy.
// The output group register is the only thing that holds up the input register.
// Reset: clears counters, open packet, axes, buttons and pending request; byte store is not
// cleared and is only read after being written within the current packet.
module six_axis_ball_packet_parser_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              kind,
	input  logic [7:0]        rx_byte,
	input  logic [7:0]        region_value,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              result_kind,
	output logic [2:0]        packet_type,
	output sabp_pkg::axis_t   axis_tx,
	output sabp_pkg::axis_t   axis_ty,
	output sabp_pkg::axis_t   axis_tz,
	output sabp_pkg::axis_t   axis_rx,
	output sabp_pkg::axis_t   axis_ry,
	output sabp_pkg::axis_t   axis_rz,
	output logic [6:0]        button_mask,
	output logic [7:0]        tx_byte,
	output logic              last
);
	import sabp_pkg::*;

	logic       v_s1;
	logic       kind_s1;
	logic [7:0] byte_s1;
	logic [7:0] region_s1;
	logic       accept, commit, has_result, grp_free;
	grp_t       grp_d;
	axes_t      axes;
	logic [6:0] buttons;

	// Item moves on unless it completes a packet while the output group is busy
	assign commit   = v_s1 && (!has_result || grp_free);
	assign in_stall = v_s1 && !commit;
	assign accept   = in_valid && !in_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (commit) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1   <= kind;
			byte_s1   <= rx_byte;
			region_s1 <= region_value;
		end
	end

	sabp_parse u_parse (
		.clk          (clk),
		.arst_n       (arst_n),
		.commit       (commit),
		.kind         (kind_s1),
		.rx_byte      (byte_s1),
		.region_value (region_s1),
		.has_result   (has_result),
		.grp_d        (grp_d),
		.axes         (axes),
		.buttons      (buttons)
	);

	sabp_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (commit && has_result),
		.grp_d       (grp_d),
		.axes        (axes),
		.buttons     (buttons),
		.grp_free    (grp_free),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result_kind (result_kind),
		.packet_type (packet_type),
		.axis_tx     (axis_tx),
		.axis_ty     (axis_ty),
		.axis_tz     (axis_tz),
		.axis_rx     (axis_rx),
		.axis_ry     (axis_ry),
		.axis_rz     (axis_rz),
		.button_mask (button_mask),
		.tx_byte     (tx_byte),
		.last        (last)
	);

`ifndef SYNTHESIS
	// A held item keeps its contents until it commits
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> v_s1 && $stable(byte_s1) && $stable(kind_s1))
		else $error("held input item changed");

	// A group does not end before its last result is transferred
	a_group_cont: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> out_valid && result_kind)
		else $error("result group cut short");

	// Reports carry a real packet type
	a_rep_type: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !result_kind |-> packet_type <= 3'd5)
		else $error("report with invalid packet type");
`endif

endmodule

// File: hw/rtl/sabp_parse.sv
// Packet framing, byte store, ball/button decode and null-region request state.
module sabp_parse (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              commit,
	input  logic              kind,
	input  logic [7:0]        rx_byte,
	input  logic [7:0]        region_value,
	output logic              has_result,
	output sabp_pkg::grp_t    grp_d,
	output sabp_pkg::axes_t   axes,
	output logic [6:0]        buttons
);
	import sabp_pkg::*;

	logic [7:0]       store_q [STORE_DEPTH];
	logic [CNT_W-1:0] cnt_q;
	pkt_t             open_q;
	axes_t            axes_q;
	logic [6:0]       buttons_q;
	logic             pend_q;
	logic [7:0]       region_q;

	logic [CNT_W-1:0] cnt1, cnt2;
	pkt_t             open0, open1, start;
	logic             ovf, in_pkt, complete, store_wr;
	logic [7:0]       b [STORE_DEPTH];
	axes_t            ball_axes;

	// Framing: overflow drop, then start byte, then append
	always_comb begin
		ovf   = cnt_q >= CNT_W'(BUFFER_BYTES - 1);
		open0 = ovf ? PKT_NONE : open_q;
		start = start_code(rx_byte);
		if (start != PKT_NONE) begin
			open1 = start;
			cnt1  = '0;
		end else begin
			open1 = open0;
			cnt1  = ovf ? '0 : cnt_q;
		end
		in_pkt   = (open1 != PKT_NONE);
		cnt2     = cnt1 + CNT_W'(1);
		complete = !kind && in_pkt && (cnt2 == pkt_len(open1));
		store_wr = !kind && in_pkt && (cnt1 < CNT_W'(STORE_DEPTH));
	end

	// Descramble stored ball bytes and pull out the six axes
	always_comb begin
		for (int i = 0; i < STORE_DEPTH; i++) begin
			b[i] = store_q[i];
		end
		for (int i = 0; i < KEY_LEN; i++) begin
			b[2 + i] = store_q[2 + i] ^ DESC_KEY[i];
		end
		ball_axes.tx = {b[2][6:0], b[3][6:4]};
		ball_axes.ty = {b[3][3:0], b[4][6:1]};
		ball_axes.tz = {b[4][0], b[5][6:0], b[6][6:5]};
		ball_axes.rx = {b[6][4:0], b[7][6:2]};
		ball_axes.ry = {b[7][1:0], b[8][6:0], b[9][6]};
		ball_axes.rz = {b[9][5:0], b[10][6:3]};
	end

	// Byte store: no reset, entries are read only after being written in the packet
	always_ff @(posedge clk) begin
		if (commit && store_wr) begin
			store_q[cnt1[STORE_IDX_W-1:0]] <= rx_byte;
		end
	end

	// Control and decoded state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			open_q    <= PKT_NONE;
			axes_q    <= '0;
			buttons_q <= '0;
			pend_q    <= 1'b0;
			region_q  <= '0;
		end else if (commit) begin
			if (kind) begin
				pend_q   <= 1'b1;
				region_q <= region_value;
			end else if (complete) begin
				cnt_q  <= '0;
				open_q <= PKT_NONE;
				pend_q <= 1'b0;
				if (open1 == PKT_BALL) begin
					axes_q <= ball_axes;
				end
				if (open1 == PKT_BUTTON) begin
					buttons_q <= store_q[2][6:0];
				end
			end else if (in_pkt) begin
				cnt_q  <= cnt2;
				open_q <= open1;
			end else begin
				cnt_q  <= cnt1;
				open_q <= open1;
			end
		end
	end

	assign has_result   = complete;
	assign grp_d.ptype  = open1;
	assign grp_d.tx_en  = pend_q && (region_q < REGION_LIMIT);
	assign grp_d.region = region_q;
	assign axes         = axes_q;
	assign buttons      = buttons_q;

endmodule

// File: hw/rtl/sabp_out.sv
// Output serializer: one report and up to three transmit bytes per completed packet.
module sabp_out (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  sabp_pkg::grp_t    grp_d,
	input  sabp_pkg::axes_t   axes,
	input  logic [6:0]        buttons,
	output logic              grp_free,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              result_kind,
	output logic [2:0]        packet_type,
	output sabp_pkg::axis_t   axis_tx,
	output sabp_pkg::axis_t   axis_ty,
	output sabp_pkg::axis_t   axis_tz,
	output sabp_pkg::axis_t   axis_rx,
	output sabp_pkg::axis_t   axis_ry,
	output sabp_pkg::axis_t   axis_rz,
	output logic [6:0]        button_mask,
	output logic [7:0]        tx_byte,
	output logic              last
);
	import sabp_pkg::*;

	logic  grp_v_q;
	slot_t slot_q;
	grp_t  grp_q;
	logic  is_rep, last_w, xfer;

	assign is_rep   = (slot_q == SLOT_REPORT);
	assign last_w   = (is_rep && !grp_q.tx_en) || (slot_q == SLOT_CR);
	assign xfer     = grp_v_q && !out_stall;
	assign grp_free = !grp_v_q || (xfer && last_w);

	// Group valid and slot counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_v_q <= 1'b0;
			slot_q  <= SLOT_REPORT;
		end else if (load) begin
			grp_v_q <= 1'b1;
			slot_q  <= SLOT_REPORT;
		end else if (xfer) begin
			if (last_w) begin
				grp_v_q <= 1'b0;
			end else begin
				slot_q <= slot_t'(slot_q + 2'd1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			grp_q <= grp_d;
		end
	end

	// Result fields; axes and buttons come from parser state, which only
	// changes when a new group loads
	always_comb begin
		case (slot_q)
			SLOT_N:      tx_byte = CH_NULL;
			SLOT_REGION: tx_byte = grp_q.region;
			SLOT_CR:     tx_byte = CH_CR;
			default:     tx_byte = '0;
		endcase
	end

	assign out_valid   = grp_v_q;
	assign result_kind = !is_rep;
	assign packet_type = is_rep ? grp_q.ptype : 3'd0;
	assign axis_tx     = is_rep ? axes.tx : '0;
	assign axis_ty     = is_rep ? axes.ty : '0;
	assign axis_tz     = is_rep ? axes.tz : '0;
	assign axis_rx     = is_rep ? axes.rx : '0;
	assign axis_ry     = is_rep ? axes.ry : '0;
	assign axis_rz     = is_rep ? axes.rz : '0;
	assign button_mask = is_rep ? buttons : '0;
	assign last        = last_w;

endmodule
